// ===== rtl/assert_macros.svh =====
// Assertion macros for the top level of the handoff station selector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define HSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define HSS_ASSERT_NEXT(lbl, cond, nxt, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) \
        else $error(msg);

`endif

// ===== rtl/hss_pkg.sv =====
// Shared types, constants and codes of the handoff station selector.
`default_nettype none

package hss_pkg;

    localparam int POWER_W          = 13;
    localparam int ID_W             = 4;
    localparam int MARGIN_W         = 12;
    localparam int NUM_POLICIES     = 4;
    localparam int MAX_IDS          = 1 << ID_W;
    localparam int NUM_STATIONS_DEF = 16;
    localparam int APB_AW           = 3;
    localparam int APB_DW           = 32;

    typedef logic signed [POWER_W-1:0] t_power;
    typedef logic [ID_W-1:0]           t_id;
    typedef logic [MARGIN_W-1:0]       t_margin;

    localparam t_power  POWER_MIN     = {1'b1, {(POWER_W-1){1'b0}}};
    localparam t_power  MIN_POWER_RST = t_power'(-1600);
    localparam t_margin MARGIN_RST    = t_margin'(80);

    typedef enum logic [1:0] {
        POL_THRESHOLD = 2'd0,
        POL_BEST      = 2'd1,
        POL_HYST      = 2'd2,
        POL_AVERAGE   = 2'd3
    } t_policy;

    typedef enum logic [0:0] {
        REG_MIN_POWER = 1'b0,
        REG_MARGIN    = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_id    idx;
        logic   idx_ok;
        t_power power;
        logic   refresh;
        logic   last;
    } t_item;

    typedef struct packed {
        t_power best_power;
        t_id    best_id;
        t_id    best_avg_id;
    } t_round_sum;

    typedef struct packed {
        t_id [NUM_POLICIES-1:0]  choice;
        logic [NUM_POLICIES-1:0] changed;
        logic                    best_below_min;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/hss_avg_store.sv =====
// Per-station running average store with halving update.
`default_nettype none

module hss_avg_store
    import hss_pkg::*;
#(
    parameter int NUM_STATIONS = NUM_STATIONS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    input  wire t_item  i_item,
    output t_power      o_avg_new
);

    localparam int DEPTH = (NUM_STATIONS < MAX_IDS) ? NUM_STATIONS : MAX_IDS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_power                  r_avg [DEPTH];
    logic [AW-1:0]           w_addr;
    logic signed [POWER_W:0] w_sum;

    assign w_addr    = i_item.idx_ok ? i_item.idx[AW-1:0] : '0;
    assign w_sum     = (POWER_W+1)'(i_item.power) + (POWER_W+1)'(r_avg[w_addr]);
    // floor halving: drop the low bit of the sign-extended sum
    assign o_avg_new = w_sum[POWER_W:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_avg[i] <= '0;
            end
        end else if (i_en && i_item.idx_ok) begin
            r_avg[w_addr] <= o_avg_new;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hss_round_tracker.sv =====
// Per-round tracking of the strongest power and the strongest average.
`default_nettype none

module hss_round_tracker
    import hss_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_en,
    input  wire t_item  i_item,
    input  wire t_power i_avg_new,
    output t_round_sum  o_sum
);

    t_power r_best_power;
    t_id    r_best_id;
    t_power r_best_avg;
    t_id    r_best_avg_id;

    logic   w_upd_power;
    logic   w_upd_avg;
    t_power n_best_avg;

    // strictly greater only, so the earliest item keeps a tie
    assign w_upd_power = i_item.idx_ok && (i_item.power > r_best_power);
    assign w_upd_avg   = i_item.idx_ok && (i_avg_new > r_best_avg);
    assign n_best_avg  = w_upd_avg ? i_avg_new : r_best_avg;

    assign o_sum.best_power  = w_upd_power ? i_item.power : r_best_power;
    assign o_sum.best_id     = w_upd_power ? i_item.idx : r_best_id;
    assign o_sum.best_avg_id = w_upd_avg ? i_item.idx : r_best_avg_id;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_item.last)) begin
            r_best_power  <= POWER_MIN;
            r_best_id     <= '0;
            r_best_avg    <= '0;
            r_best_avg_id <= '0;
        end else if (i_en) begin
            r_best_power  <= o_sum.best_power;
            r_best_id     <= o_sum.best_id;
            r_best_avg    <= n_best_avg;
            r_best_avg_id <= o_sum.best_avg_id;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hss_policy_unit.sv =====
// Serving state and round-end decisions of the four handoff policies.
`default_nettype none

module hss_policy_unit
    import hss_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire t_item      i_item,
    input  wire t_round_sum i_sum,
    input  wire t_power     i_min_power,
    input  wire t_margin    i_margin,
    output t_result         o_result
);

    localparam int DIFF_W = POWER_W + 2;

    t_id    r_sid [NUM_POLICIES];
    logic   r_sv  [NUM_POLICIES];
    t_power r_sp  [NUM_POLICIES];

    t_power                  w_sp     [NUM_POLICIES];
    t_id                     w_target [NUM_POLICIES];
    logic [NUM_POLICIES-1:0] w_sw;
    logic [NUM_POLICIES-1:0] w_chg;
    t_id                     n_sid    [NUM_POLICIES];
    logic signed [DIFF_W-1:0] w_diff;
    logic signed [DIFF_W-1:0] w_margin;

    // the latest power seen this round for each serving station
    always_comb begin
        for (int k = 0; k < NUM_POLICIES; k++) begin
            w_sp[k] = (i_item.idx_ok && (r_sid[k] == i_item.idx)) ? i_item.power : r_sp[k];
        end
    end

    assign w_diff   = DIFF_W'(i_sum.best_power) - DIFF_W'(w_sp[POL_HYST]);
    assign w_margin = signed'({{(DIFF_W-MARGIN_W){1'b0}}, i_margin});

    always_comb begin
        w_sw[POL_THRESHOLD] = !r_sv[POL_THRESHOLD] || (w_sp[POL_THRESHOLD] < i_min_power);
        w_sw[POL_BEST]      = !r_sv[POL_BEST] || (w_sp[POL_BEST] != i_sum.best_power);
        w_sw[POL_HYST]      = !r_sv[POL_HYST] || (w_diff > w_margin)
                              || (w_sp[POL_HYST] < i_min_power);
        w_sw[POL_AVERAGE]   = !r_sv[POL_AVERAGE] || (w_sp[POL_AVERAGE] < i_min_power)
                              || i_item.refresh;
        for (int k = 0; k < NUM_POLICIES; k++) begin
            w_target[k] = (k == int'(POL_AVERAGE)) ? i_sum.best_avg_id : i_sum.best_id;
            w_chg[k]    = w_sw[k] && !(r_sv[k] && (r_sid[k] == w_target[k]));
            n_sid[k]    = w_chg[k] ? w_target[k] : r_sid[k];
            o_result.choice[k] = n_sid[k];
        end
        o_result.changed        = w_chg;
        o_result.best_below_min = i_sum.best_power < i_min_power;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_POLICIES; k++) begin
                r_sid[k] <= '0;
                r_sv[k]  <= 1'b0;
                r_sp[k]  <= '0;
            end
        end else if (i_en) begin
            for (int k = 0; k < NUM_POLICIES; k++) begin
                if (i_item.last) begin
                    r_sid[k] <= n_sid[k];
                    r_sv[k]  <= r_sv[k] || w_chg[k];
                    r_sp[k]  <= '0;
                end else begin
                    r_sp[k]  <= w_sp[k];
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/handoff_station_selector.sv =====
// Top level of the handoff station selector: channels, registers and the datapath.
`default_nettype none
`include "assert_macros.svh"

// Handoff station selector. Each transfer on the input channel carries one
// station's received power (signed, 1/16 dB steps) for the current round; the
// transfer flagged last_station closes the round and yields exactly one result
// transfer with the serving station of four policies (threshold, strongest,
// hysteresis, averaged), their change flags and a flag for a round whose
// strongest power lies below min_power. Other transfers yield no result.
// Rate: one input transfer per cycle, sustained, as long as the output side
// takes results; the closing input transfer passes the input register and
// then the result register, which raises o_out_valid. The rate rests on the
// per-station average store, read and halved combinationally and written back
// as the item advances, next to the round trackers and the policy
// logic, all between the input register and the result register. Station
// indices at or above NUM_STATIONS are dropped, but a last_station flag on
// them still closes the round. Averages reset to zero; the store covers at
// most the sixteen indices that the index field can name. Registers sit on an
// APB-style port: min_power at 0x0 (13-bit signed), hysteresis_margin at 0x4
// (12-bit unsigned); write them only while the block is idle.
module handoff_station_selector
    import hss_pkg::*;
#(
    parameter int NUM_STATIONS = NUM_STATIONS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input channel
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [ID_W-1:0]   i_station_index,
    input  wire logic signed [POWER_W-1:0] i_rx_power,
    input  wire logic              i_refresh_event,
    input  wire logic              i_last_station,
    // result channel
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [ID_W-1:0]        o_threshold_choice,
    output logic [ID_W-1:0]        o_best_choice,
    output logic [ID_W-1:0]        o_hysteresis_choice,
    output logic [ID_W-1:0]        o_average_choice,
    output logic                   o_threshold_changed,
    output logic                   o_best_changed,
    output logic                   o_hysteresis_changed,
    output logic                   o_average_changed,
    output logic                   o_best_below_min,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    // configuration registers
    t_power     r_min_power;
    t_margin    r_margin;
    t_reg_idx   w_reg_idx;
    logic       w_cfg_wr;

    // input register and result register
    t_item      r_in;
    logic       r_in_valid;
    logic       n_in_valid;
    t_result    r_out;
    logic       r_out_valid;
    logic       n_out_valid;

    logic       w_adv;
    logic       w_take;
    t_item      w_item;
    t_power     w_avg_new;
    t_round_sum w_sum;
    t_result    w_result;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[2]);
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        case (w_reg_idx)
            REG_MIN_POWER: prdata = APB_DW'(r_min_power);
            REG_MARGIN:    prdata = APB_DW'(r_margin);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_power <= MIN_POWER_RST;
            r_margin    <= MARGIN_RST;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_MIN_POWER: r_min_power <= pwdata[POWER_W-1:0];
                REG_MARGIN:    r_margin    <= pwdata[MARGIN_W-1:0];
                default:       ;
            endcase
        end
    end

    // ---------------- input register ----------------
    // Advance the held item unless it closes a round and the result register
    // is still full and not being taken; items that yield no result never wait.
    assign w_adv      = r_in_valid && (!r_in.last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;
    assign w_take     = i_in_valid && o_in_ready;

    assign w_item.idx     = i_station_index;
    assign w_item.idx_ok  = int'(i_station_index) < NUM_STATIONS;
    assign w_item.power   = i_rx_power;
    assign w_item.refresh = i_refresh_event;
    assign w_item.last    = i_last_station;

    assign n_in_valid = w_take || (r_in_valid && !w_adv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in <= w_item;
        end
    end

    // ---------------- datapath ----------------
    hss_avg_store #(
        .NUM_STATIONS (NUM_STATIONS)
    ) u_avg_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_adv),
        .i_item    (r_in),
        .o_avg_new (w_avg_new)
    );

    hss_round_tracker u_round_tracker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_adv),
        .i_item    (r_in),
        .i_avg_new (w_avg_new),
        .o_sum     (w_sum)
    );

    hss_policy_unit u_policy_unit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_adv),
        .i_item      (r_in),
        .i_sum       (w_sum),
        .i_min_power (r_min_power),
        .i_margin    (r_margin),
        .o_result    (w_result)
    );

    // ---------------- result register ----------------
    // Load on a round close; drop once the result transfer completes.
    assign n_out_valid = (w_adv && r_in.last) || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in.last) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_threshold_choice   = r_out.choice[POL_THRESHOLD];
    assign o_best_choice        = r_out.choice[POL_BEST];
    assign o_hysteresis_choice  = r_out.choice[POL_HYST];
    assign o_average_choice     = r_out.choice[POL_AVERAGE];
    assign o_threshold_changed  = r_out.changed[POL_THRESHOLD];
    assign o_best_changed       = r_out.changed[POL_BEST];
    assign o_hysteresis_changed = r_out.changed[POL_HYST];
    assign o_average_changed    = r_out.changed[POL_AVERAGE];
    assign o_best_below_min     = r_out.best_below_min;

    // ---------------- assertions ----------------
    `HSS_ASSERT(a_stall_needs_item, !o_in_ready |-> r_in_valid, "ready low with empty input register")
    `HSS_ASSERT_NEXT(a_close_gives_result, w_adv && r_in.last, o_out_valid, "round close without result")
    `HSS_ASSERT(a_no_overwrite, (r_in_valid && r_in.last && r_out_valid && !i_out_ready) |-> !w_adv, "result register overwritten while stalled")

endmodule

`default_nettype wire
